[hdl/iea_pkg.sv]
// Shared types, codes and constants for the input event aggregator.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package iea_pkg;

  // Key map geometry: the map is kept as rows of 64 key bits.
  localparam int KeyCount   = 256;
  localparam int RowBits    = 64;
  localparam int ChunkCount = 4;
  localparam int RowIdxW    = $clog2(ChunkCount);
  localparam int KeyIdxW    = 8;
  localparam int BitIdxW    = $clog2(RowBits);

  // Field widths.
  localparam int OpW       = 2;
  localparam int HalfW     = 16;
  localparam int PosW      = 12;
  localparam int ScreenW   = 13;
  localparam int CfgIdxW   = 8;
  localparam int InDataW   = 48;
  localparam int OutDataW  = 144;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = CfgIdxW'(1);

  localparam logic [ScreenW-1:0] ScreenWidthRst  = ScreenW'(640);
  localparam logic [ScreenW-1:0] ScreenHeightRst = ScreenW'(480);

  // Event types and codes.
  localparam logic [HalfW-1:0] TypeKey      = 16'h0001;
  localparam logic [HalfW-1:0] TypeRel      = 16'h0002;
  localparam logic [HalfW-1:0] CodeRelX     = 16'h0000;
  localparam logic [HalfW-1:0] CodeRelY     = 16'h0001;
  localparam logic [HalfW-1:0] CodeWheel    = 16'h0008;
  localparam logic [HalfW-1:0] CodeBtnLeft  = 16'h0110;
  localparam logic [HalfW-1:0] CodeBtnRight = 16'h0111;
  localparam logic [HalfW-1:0] CodeBtnMid   = 16'h0112;

  localparam logic [KeyIdxW-1:0] KeyShiftL = 8'd42;
  localparam logic [KeyIdxW-1:0] KeyShiftR = 8'd54;
  localparam logic [KeyIdxW-1:0] KeyCtrlL  = 8'd29;
  localparam logic [KeyIdxW-1:0] KeyAltL   = 8'd56;
  localparam logic [KeyIdxW-1:0] KeyCaps   = 8'd58;

  // Item kinds carried in the input tuser.
  typedef enum logic [OpW-1:0] {
    OP_MOUSE = 2'd0,
    OP_KBD   = 2'd1,
    OP_POLL  = 2'd2
  } op_e;

  // One event as it travels from the input decode to the state units.
  typedef struct packed {
    logic [HalfW-1:0]        ev_type;
    logic [HalfW-1:0]        code;
    logic signed [HalfW-1:0] value;
  } event_t;

  // Which unit the accepted beat is meant for.
  typedef struct packed {
    logic mouse;
    logic kbd;
    logic poll;
  } ev_sel_t;

  // Modifier flags.
  typedef struct packed {
    logic caps;
    logic alt;
    logic ctrl;
    logic shift;
  } mods_t;

  // Pointer and motion values captured by a poll.
  typedef struct packed {
    logic [PosW-1:0]         pos_x;
    logic [PosW-1:0]         pos_y;
    logic signed [HalfW-1:0] dx;
    logic signed [HalfW-1:0] dy;
    logic signed [HalfW-1:0] wheel;
    logic [2:0]              buttons;
  } motion_snap_t;

  // Bits of a row that stand for keys below KeyCount.
  function automatic logic [RowBits-1:0] key_row_mask(logic [RowIdxW-1:0] row);
    int lo;
    logic [RowBits-1:0] m;
    lo = RowBits * int'(row);
    if (lo >= KeyCount) begin
      m = '0;
    end else if (KeyCount - lo < RowBits) begin
      m = (RowBits'(1) << (KeyCount - lo)) - RowBits'(1);
    end else begin
      m = '1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/input_event_aggregator.sv]
// Top level of the input event aggregator: stream ports, configuration,
// poll sequencer and output register. Depends on iea_pkg, iea_motion, iea_key_map.
//
// Channel  Direction  Beat contents
// s_axis   in         tuser: op; tdata: event_type, event_code, event_value
// m_axis   out        tdata: snapshot fields and 64 key bits; tlast: final chunk
// cfg      in         cfg_index_i: register index; cfg_data_i: value
//
// Mouse and keyboard events are taken one per cycle, back to back.
// A poll holds the input until its final chunk is loaded: the first key map row
// is read, then one chunk per cycle follows from the row memory port while the
// output is free; an output stall holds it. Key rows read as cleared after reset
// through per-row valid flags, with no clearing pass. Configuration is always ready.
`timescale 1ns / 1ps
`default_nettype none

module input_event_aggregator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] event_type, [31:16] event_code, [47:32] event_value
  input  wire logic [iea_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] op
  input  wire logic [iea_pkg::OpW-1:0]       s_axis_tuser,
  // Output stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [11:0] pos_x, [23:12] pos_y, [39:24] delta_x, [55:40] delta_y,
  // [71:56] wheel_delta, [74:72] buttons, [75] shift_held, [76] ctrl_held,
  // [77] alt_held, [78] caps_lock_on, [142:79] key_bits, [143] zero
  output logic [iea_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                               m_axis_tlast,
  // Configuration writes.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [iea_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [iea_pkg::ScreenW-1:0]   cfg_data_i
);
  import iea_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POLL = 2'b10
  } seq_state_e;

  seq_state_e          st_q, st_d;
  logic [RowIdxW-1:0]  poll_row_q, poll_row_d, rd_row;
  logic                have_q, have_d;
  logic                in_acc, out_free, out_load;
  ev_sel_t             sel;
  event_t              ev;
  motion_snap_t        snap;
  mods_t               mods, mods_snap_q;
  logic [RowBits-1:0]  row_data;
  logic [ScreenW-1:0]  scr_w_q, scr_h_q;

  logic                out_vld_q;
  motion_snap_t        out_snap_q;
  mods_t               out_mods_q;
  logic [RowBits-1:0]  out_keys_q;
  logic                out_last_q;

  // Input decode.
  assign s_axis_tready = (st_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ev.ev_type    = s_axis_tdata[15:0];
  assign ev.code       = s_axis_tdata[31:16];
  assign ev.value      = s_axis_tdata[47:32];

  always_comb begin
    sel = '0;
    case (op_e'(s_axis_tuser))
      OP_MOUSE: sel.mouse = in_acc;
      OP_KBD:   sel.kbd   = in_acc;
      OP_POLL:  sel.poll  = in_acc;
      default:  sel       = '0;
    endcase
  end

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q <= ScreenWidthRst;
      scr_h_q <= ScreenHeightRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgScreenWidth)  scr_w_q <= cfg_data_i;
      if (cfg_index_i == CfgScreenHeight) scr_h_q <= cfg_data_i;
    end
  end

  iea_motion u_motion (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sel_i      (sel),
    .ev_i       (ev),
    .screen_w_i (scr_w_q),
    .screen_h_i (scr_h_q),
    .snap_o     (snap)
  );

  iea_key_map u_key_map (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .kbd_i      (sel.kbd),
    .ev_i       (ev),
    .poll_row_i (rd_row),
    .row_data_o (row_data),
    .mods_o     (mods)
  );

  // Poll sequencer: walks the key rows, one chunk per output beat.
  assign out_free = !out_vld_q || m_axis_tready;
  assign out_load = (st_q == ST_POLL) && have_q && out_free;
  assign rd_row   = out_load ? poll_row_q + RowIdxW'(1) : poll_row_q;

  always_comb begin
    st_d       = st_q;
    poll_row_d = poll_row_q;
    have_d     = have_q;
    case (st_q)
      ST_IDLE: begin
        if (sel.poll) begin
          st_d       = ST_POLL;
          poll_row_d = '0;
          have_d     = 1'b0;
        end
      end
      ST_POLL: begin
        have_d = 1'b1;
        if (out_load) begin
          if (poll_row_q == RowIdxW'(ChunkCount - 1)) begin
            st_d = ST_IDLE;
          end else begin
            poll_row_d = poll_row_q + RowIdxW'(1);
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      poll_row_q <= '0;
      have_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      poll_row_q <= poll_row_d;
      have_q     <= have_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Modifiers are captured with the poll; output payload loads per chunk.
  always_ff @(posedge clk_i) begin
    if (sel.poll) begin
      mods_snap_q <= mods;
    end
    if (out_load) begin
      out_snap_q <= snap;
      out_mods_q <= mods_snap_q;
      out_keys_q <= row_data;
      out_last_q <= (poll_row_q == RowIdxW'(ChunkCount - 1));
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {1'b0, out_keys_q,
                          out_mods_q.caps, out_mods_q.alt, out_mods_q.ctrl,
                          out_mods_q.shift, out_snap_q.buttons,
                          out_snap_q.wheel, out_snap_q.dy, out_snap_q.dx,
                          out_snap_q.pos_y, out_snap_q.pos_x};

`ifndef SYNTHESIS
  // No event is taken while a poll is being sent out.
  a_hold_during_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_POLL) |-> !s_axis_tready)
    else $error("input ready during poll sequence");

  // A poll starts the row walk at the first row.
  a_poll_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel.poll |=> (st_q == ST_POLL) && (poll_row_q == '0) && !have_q)
    else $error("poll did not start at the first row");

  // Loading the final chunk ends the sequence and marks the beat as last.
  a_last_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && poll_row_q == RowIdxW'(ChunkCount - 1))
      |=> (st_q == ST_IDLE) && m_axis_tvalid && m_axis_tlast)
    else $error("final chunk not flagged or sequence not ended");

  // Only the final chunk carries the last flag.
  a_last_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && poll_row_q != RowIdxW'(ChunkCount - 1)) |=> !m_axis_tlast)
    else $error("last flag on an inner chunk");
`endif

endmodule

`default_nettype wire

[hdl/iea_motion.sv]
// Mouse state: saturating motion deltas, button bits and the clamped pointer.
// Depends on iea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iea_motion (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire iea_pkg::ev_sel_t              sel_i,
  input  wire iea_pkg::event_t               ev_i,
  input  wire logic [iea_pkg::ScreenW-1:0]   screen_w_i,
  input  wire logic [iea_pkg::ScreenW-1:0]   screen_h_i,
  output iea_pkg::motion_snap_t              snap_o
);
  import iea_pkg::*;

  logic [PosW-1:0]         ptr_x_q, ptr_y_q, ptr_x_d, ptr_y_d;
  logic signed [HalfW-1:0] acc_dx_q, acc_dy_q, acc_wh_q;
  logic signed [HalfW-1:0] acc_dx_d, acc_dy_d, acc_wh_d;
  logic [2:0]              btn_q, btn_d;
  motion_snap_t            snap_q, snap_d;
  logic                    pressed;

  // Add with saturation to the 16-bit signed range.
  function automatic logic signed [HalfW-1:0] sat_add(logic signed [HalfW-1:0] a,
                                                      logic signed [HalfW-1:0] b);
    logic signed [HalfW:0] s;
    logic signed [HalfW-1:0] r;
    s = (HalfW+1)'(a) + (HalfW+1)'(b);
    if (s[HalfW] != s[HalfW-1]) begin
      r = s[HalfW] ? {1'b1, {(HalfW-1){1'b0}}} : {1'b0, {(HalfW-1){1'b1}}};
    end else begin
      r = s[HalfW-1:0];
    end
    return r;
  endfunction

  // Move a coordinate and clamp it to the screen, at most 4095.
  function automatic logic [PosW-1:0] clamp_pos(logic [PosW-1:0] pos,
                                                logic signed [HalfW-1:0] dlt,
                                                logic [ScreenW-1:0] size);
    logic signed [HalfW+1:0] p;
    logic [ScreenW-1:0]      lim_full;
    logic [PosW-1:0]         lim;
    logic [PosW-1:0]         r;
    p = $signed({{(HalfW+2-PosW){1'b0}}, pos}) + (HalfW+2)'(dlt);
    lim_full = (size == '0) ? '0 : size - ScreenW'(1);
    lim = (lim_full > ScreenW'({PosW{1'b1}})) ? {PosW{1'b1}} : lim_full[PosW-1:0];
    if (p < 0) begin
      r = '0;
    end else if (p > $signed({{(HalfW+2-PosW){1'b0}}, lim})) begin
      r = lim;
    end else begin
      r = p[PosW-1:0];
    end
    return r;
  endfunction

  assign pressed = (ev_i.value != '0);

  // Next state for mouse events and polls.
  always_comb begin
    ptr_x_d  = ptr_x_q;
    ptr_y_d  = ptr_y_q;
    acc_dx_d = acc_dx_q;
    acc_dy_d = acc_dy_q;
    acc_wh_d = acc_wh_q;
    btn_d    = btn_q;
    snap_d   = snap_q;
    if (sel_i.poll) begin
      ptr_x_d        = clamp_pos(ptr_x_q, acc_dx_q, screen_w_i);
      ptr_y_d        = clamp_pos(ptr_y_q, acc_dy_q, screen_h_i);
      snap_d.pos_x   = ptr_x_d;
      snap_d.pos_y   = ptr_y_d;
      snap_d.dx      = acc_dx_q;
      snap_d.dy      = acc_dy_q;
      snap_d.wheel   = acc_wh_q;
      snap_d.buttons = btn_q;
      acc_dx_d       = '0;
      acc_dy_d       = '0;
      acc_wh_d       = '0;
    end else if (sel_i.mouse) begin
      if (ev_i.ev_type == TypeRel) begin
        if (ev_i.code == CodeRelX)  acc_dx_d = sat_add(acc_dx_q, ev_i.value);
        if (ev_i.code == CodeRelY)  acc_dy_d = sat_add(acc_dy_q, ev_i.value);
        if (ev_i.code == CodeWheel) acc_wh_d = sat_add(acc_wh_q, ev_i.value);
      end else if (ev_i.ev_type == TypeKey) begin
        if (ev_i.code == CodeBtnLeft)  btn_d[0] = pressed;
        if (ev_i.code == CodeBtnRight) btn_d[1] = pressed;
        if (ev_i.code == CodeBtnMid)   btn_d[2] = pressed;
      end
    end
  end

  // Motion state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_x_q  <= '0;
      ptr_y_q  <= '0;
      acc_dx_q <= '0;
      acc_dy_q <= '0;
      acc_wh_q <= '0;
      btn_q    <= '0;
    end else begin
      ptr_x_q  <= ptr_x_d;
      ptr_y_q  <= ptr_y_d;
      acc_dx_q <= acc_dx_d;
      acc_dy_q <= acc_dy_d;
      acc_wh_q <= acc_wh_d;
      btn_q    <= btn_d;
    end
  end

  // The snapshot is payload, written only by a poll.
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
  end

  assign snap_o = snap_q;

endmodule

`default_nettype wire

[hdl/iea_key_map.sv]
// Key map held in a synchronous row memory with read-modify-write, plus the
// keyboard modifier flags. Depends on iea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iea_key_map (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          kbd_i,
  input  wire iea_pkg::event_t               ev_i,
  input  wire logic [iea_pkg::RowIdxW-1:0]   poll_row_i,
  output logic [iea_pkg::RowBits-1:0]        row_data_o,
  output iea_pkg::mods_t                     mods_o
);
  import iea_pkg::*;

  logic [RowBits-1:0]    key_mem_q [ChunkCount];
  logic [RowBits-1:0]    rdata_q;
  logic [RowIdxW-1:0]    rd_row_q, rd_addr;
  logic [ChunkCount-1:0] row_vld_q;

  logic                  key_ev, pressed, in_range;
  logic [KeyIdxW-1:0]    key_idx;
  logic                  s1_vld_q, s1_set_q;
  logic [RowIdxW-1:0]    s1_row_q;
  logic [BitIdxW-1:0]    s1_bit_q;

  logic                  wr_vld_q;
  logic [RowIdxW-1:0]    wr_row_q;
  logic [RowBits-1:0]    wr_data_q;
  logic [RowBits-1:0]    row_base, row_new, rd_base;

  mods_t                 mods_q, mods_d;

  assign key_ev   = kbd_i && (ev_i.ev_type == TypeKey);
  assign key_idx  = ev_i.code[KeyIdxW-1:0];
  assign pressed  = (ev_i.value != '0);
  assign in_range = ({1'b0, key_idx} < (KeyIdxW+1)'(KeyCount));

  // A key event reads its row; otherwise the poll sequencer owns the port.
  assign rd_addr = key_ev ? key_idx[KeyIdxW-1 -: RowIdxW] : poll_row_i;

  // Row memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      key_mem_q[s1_row_q] <= row_new;
    end
    rdata_q <= key_mem_q[rd_addr];
  end

  // The row written on the previous edge is not yet in the read data.
  always_comb begin
    if (wr_vld_q && (wr_row_q == s1_row_q)) begin
      row_base = wr_data_q;
    end else if (row_vld_q[s1_row_q]) begin
      row_base = rdata_q;
    end else begin
      row_base = '0;
    end
    row_new = row_base;
    row_new[s1_bit_q] = s1_set_q;
  end

  // Modifier updates follow the low byte of the key code.
  always_comb begin
    mods_d = mods_q;
    if (key_ev) begin
      if (key_idx == KeyShiftL || key_idx == KeyShiftR) mods_d.shift = pressed;
      if (key_idx == KeyCtrlL) mods_d.ctrl = pressed;
      if (key_idx == KeyAltL)  mods_d.alt  = pressed;
      if (key_idx == KeyCaps && pressed) mods_d.caps = ~mods_q.caps;
    end
  end

  // Control state: write stage, row valid flags and modifiers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      wr_vld_q  <= 1'b0;
      row_vld_q <= '0;
      mods_q    <= '0;
    end else begin
      s1_vld_q <= key_ev && in_range;
      wr_vld_q <= s1_vld_q;
      mods_q   <= mods_d;
      if (s1_vld_q) begin
        row_vld_q[s1_row_q] <= 1'b1;
      end
    end
  end

  // Payload of the write stage and the forwarding copy.
  always_ff @(posedge clk_i) begin
    s1_row_q  <= key_idx[KeyIdxW-1 -: RowIdxW];
    s1_bit_q  <= key_idx[BitIdxW-1:0];
    s1_set_q  <= pressed;
    rd_row_q  <= rd_addr;
    wr_row_q  <= s1_row_q;
    wr_data_q <= row_new;
  end

  // Poll read data: unwritten rows read as cleared, keys past the map as zero.
  assign rd_base    = row_vld_q[rd_row_q] ? rdata_q : '0;
  assign row_data_o = rd_base & key_row_mask(rd_row_q);
  assign mods_o     = mods_q;

`ifndef SYNTHESIS
  // A write stage entry always comes from a key event in the previous cycle.
  a_s1_from_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> $past(key_ev))
    else $error("key write stage without a key event");

  // After a write, that row is marked as holding data.
  a_row_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> row_vld_q[$past(s1_row_q)])
    else $error("written key row not marked valid");

  // The forwarding copy matches the row that was just written.
  a_fwd_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> (wr_vld_q && wr_row_q == $past(s1_row_q)))
    else $error("forwarding copy lost a write");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the input event aggregator: drives event beats,
// polls and screen-size writes, and checks every snapshot beat. Depends on iea_pkg.
`timescale 1ns / 1ps

module tb;
  import iea_pkg::*;

  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned PhaseItems   = 39;
  localparam int unsigned ReportLimit  = 10;

  // Codes the package does not name.
  localparam logic [OpW-1:0]   OpUnused = 2'd3;
  localparam logic [HalfW-1:0] TypeSync = 16'h0000;

  // One snapshot beat as it sits on m_axis_tdata, highest field first.
  typedef struct packed {
    logic              pad;
    logic [RowBits-1:0] key_bits;
    logic              caps;
    logic              alt;
    logic              ctrl;
    logic              shift;
    logic [2:0]        buttons;
    logic [HalfW-1:0]  wheel;
    logic [HalfW-1:0]  dy;
    logic [HalfW-1:0]  dx;
    logic [PosW-1:0]   pos_y;
    logic [PosW-1:0]   pos_x;
  } snap_word_t;

  typedef struct {
    snap_word_t word;
    logic       last;
  } snapshot_t;

  // Tracks pointer, motion, button, key and modifier state and predicts snapshots.
  class event_state_tracker;
    int                 ptr_x = 0;
    int                 ptr_y = 0;
    int                 acc_dx = 0;
    int                 acc_dy = 0;
    int                 acc_wheel = 0;
    logic [2:0]         btn = '0;
    logic [KeyCount-1:0] keys = '0;
    mods_t              mods = '0;
    logic [ScreenW-1:0] scr_w = ScreenWidthRst;
    logic [ScreenW-1:0] scr_h = ScreenHeightRst;
    snapshot_t          snapshots_due[$];
    int unsigned        mismatches = 0;

    function int sat_add(int a, int b);
      int s;
      s = a + b;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s;
    endfunction

    function int clamp_pos(int pos, int delta, logic [ScreenW-1:0] size);
      int p;
      int lim;
      p = pos + delta;
      lim = (size == 0) ? 0 : int'(size) - 1;
      if (lim > 4095) lim = 4095;
      if (p < 0) p = 0;
      if (p > lim) p = lim;
      return p;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ScreenW-1:0] value);
      if (idx == CfgScreenWidth) scr_w = value;
      else if (idx == CfgScreenHeight) scr_h = value;
    endfunction

    function void take_event(logic [OpW-1:0] op, logic [HalfW-1:0] ev_type,
                             logic [HalfW-1:0] code, logic signed [HalfW-1:0] value);
      logic             pressed;
      logic [KeyIdxW-1:0] k;
      snapshot_t        snap;
      pressed = (value != 0);
      k = code[KeyIdxW-1:0];
      case (op)
        OP_MOUSE: begin
          if (ev_type == TypeRel) begin
            if (code == CodeRelX) acc_dx = sat_add(acc_dx, int'(value));
            if (code == CodeRelY) acc_dy = sat_add(acc_dy, int'(value));
            if (code == CodeWheel) acc_wheel = sat_add(acc_wheel, int'(value));
          end else if (ev_type == TypeKey) begin
            if (code == CodeBtnLeft) btn[0] = pressed;
            if (code == CodeBtnRight) btn[1] = pressed;
            if (code == CodeBtnMid) btn[2] = pressed;
          end
        end
        OP_KBD: begin
          if (ev_type == TypeKey) begin
            if (int'(k) < KeyCount) keys[k] = pressed;
            if (k == KeyShiftL || k == KeyShiftR) mods.shift = pressed;
            if (k == KeyCtrlL) mods.ctrl = pressed;
            if (k == KeyAltL) mods.alt = pressed;
            if (k == KeyCaps && pressed) mods.caps = !mods.caps;
          end
        end
        OP_POLL: begin
          // Apply the motion, then queue one beat per row of the key map.
          ptr_x = clamp_pos(ptr_x, acc_dx, scr_w);
          ptr_y = clamp_pos(ptr_y, acc_dy, scr_h);
          for (int n = 0; n < ChunkCount; n++) begin
            snap.word.pad      = 1'b0;
            snap.word.key_bits = keys[n*RowBits +: RowBits];
            snap.word.caps     = mods.caps;
            snap.word.alt      = mods.alt;
            snap.word.ctrl     = mods.ctrl;
            snap.word.shift    = mods.shift;
            snap.word.buttons  = btn;
            snap.word.wheel    = HalfW'(acc_wheel);
            snap.word.dy       = HalfW'(acc_dy);
            snap.word.dx       = HalfW'(acc_dx);
            snap.word.pos_y    = PosW'(ptr_y);
            snap.word.pos_x    = PosW'(ptr_x);
            snap.last          = (n == ChunkCount - 1);
            snapshots_due.push_back(snap);
          end
          acc_dx = 0;
          acc_dy = 0;
          acc_wheel = 0;
        end
        default: ;
      endcase
    endfunction

    function void compare(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: snapshot %s mismatch, expected %0h, got %0h",
                   $realtime, what, want, got);
      end
    endfunction

    function void check_snapshot(logic [OutDataW-1:0] data, logic last);
      snap_word_t got;
      snapshot_t  want;
      got = data;
      if (snapshots_due.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: snapshot beat with none expected, tdata %h", $realtime, data);
        return;
      end
      want = snapshots_due.pop_front();
      compare("pos_x", want.word.pos_x, got.pos_x);
      compare("pos_y", want.word.pos_y, got.pos_y);
      compare("delta_x", want.word.dx, got.dx);
      compare("delta_y", want.word.dy, got.dy);
      compare("wheel_delta", want.word.wheel, got.wheel);
      compare("buttons", want.word.buttons, got.buttons);
      compare("shift_held", want.word.shift, got.shift);
      compare("ctrl_held", want.word.ctrl, got.ctrl);
      compare("alt_held", want.word.alt, got.alt);
      compare("caps_lock_on", want.word.caps, got.caps);
      compare("key_bits", want.word.key_bits, got.key_bits);
      compare("padding", want.word.pad, got.pad);
      compare("last", want.last, last);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic [OpW-1:0]       s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ScreenW-1:0]   cfg_data_i = '0;

  event_state_tracker   tracker = new();
  int unsigned          cycle_count = 0;
  int unsigned          send_idle_pct = 0;
  int unsigned          recv_idle_pct = 0;
  logic                 hold_off = 1'b0;
  logic                 pressure_go = 1'b0;

  input_event_aggregator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random back-pressure, or a long hold-off while pressure is on.
  always @(posedge clk_i) begin
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver stall, counted here so the sender keeps offering beats.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Monitor: results are checked before the input of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_snapshot(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_event(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                           s_axis_tdata[47:32]);
      if (cfg_valid_i && cfg_ready_o)
        tracker.write_reg(cfg_index_i, cfg_data_i);
    end
  end

  // Offers one event beat and waits until it is taken.
  task automatic send_event(logic [OpW-1:0] op, logic [HalfW-1:0] ev_type,
                            logic [HalfW-1:0] code, logic [HalfW-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {value, code, ev_type};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops offering beats and lets every outstanding snapshot drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (tracker.snapshots_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes an unused register index, then the screen width and height.
  task automatic program_screen(logic [ScreenW-1:0] width, logic [ScreenW-1:0] height);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgIdxW'($urandom_range(2, 255));
    cfg_data_i  <= ScreenW'($urandom);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgScreenWidth;
    cfg_data_i  <= width;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CfgScreenHeight;
    cfg_data_i  <= height;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed mouse, keyboard and poll beats, with some noise.
  task automatic send_random_event();
    int unsigned      pick;
    logic [OpW-1:0]   op;
    logic [HalfW-1:0] ev_type;
    logic [HalfW-1:0] code;
    logic [HalfW-1:0] value;
    pick    = $urandom_range(99);
    op      = OP_MOUSE;
    ev_type = TypeRel;
    code    = CodeRelX;
    value   = HalfW'($urandom);
    if (pick < 30) begin
      case ($urandom_range(2))
        0: code = CodeRelX;
        1: code = CodeRelY;
        default: code = CodeWheel;
      endcase
      if ($urandom_range(3) != 0) value = HalfW'($urandom_range(0, 600) - 300);
    end else if (pick < 40) begin
      ev_type = TypeKey;
      case ($urandom_range(2))
        0: code = CodeBtnLeft;
        1: code = CodeBtnRight;
        default: code = CodeBtnMid;
      endcase
      if ($urandom_range(1) == 0) value = '0;
    end else if (pick < 70) begin
      op      = OP_KBD;
      ev_type = TypeKey;
      code    = HalfW'($urandom_range(255));
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0: code[7:0] = KeyShiftL;
          1: code[7:0] = KeyShiftR;
          2: code[7:0] = KeyCtrlL;
          3: code[7:0] = KeyAltL;
          default: code[7:0] = KeyCaps;
        endcase
      end
      if ($urandom_range(3) == 0) code[15:8] = 8'($urandom);
      if ($urandom_range(1) == 0) value = '0;
      else if ($urandom_range(3) != 0) value = 16'd1;
    end else if (pick < 84) begin
      op      = OP_POLL;
      ev_type = HalfW'($urandom);
      code    = HalfW'($urandom);
    end else begin
      op      = OpW'($urandom);
      ev_type = ($urandom_range(1) == 0) ? HalfW'($urandom) : HalfW'($urandom_range(3));
      code    = ($urandom_range(1) == 0) ? HalfW'($urandom) : HalfW'($urandom_range(0, 8));
    end
    send_event(op, ev_type, code, value);
  endtask

  // Stimulus.
  initial begin
    logic [ScreenW-1:0] widths[6];
    logic [ScreenW-1:0] heights[6];
    widths  = '{13'd1, 13'd8191, 13'd0, 13'd4096, 13'd0, 13'd0};
    heights = '{13'd4096, 13'd0, 13'd8191, 13'd1, 13'd0, 13'd0};
    widths[4]  = ScreenW'($urandom_range(2, 4095));
    heights[4] = ScreenW'($urandom_range(2, 4095));
    widths[5]  = ScreenW'($urandom_range(16, 200));
    heights[5] = ScreenW'($urandom_range(16, 200));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset screen size.
    send_idle_pct = 13;
    recv_idle_pct = 54;
    send_event(OP_POLL, '0, '0, '0);
    send_event(OP_MOUSE, TypeRel, CodeRelX, 16'h7FFF);
    send_event(OP_MOUSE, TypeRel, CodeRelX, 16'h0001);
    send_event(OP_MOUSE, TypeRel, CodeRelY, 16'h8000);
    send_event(OP_MOUSE, TypeRel, CodeRelY, 16'hFFFF);
    send_event(OP_MOUSE, TypeRel, CodeWheel, 16'h7FFF);
    send_event(OP_MOUSE, TypeRel, CodeWheel, 16'hFFFB);
    send_event(OP_MOUSE, TypeKey, CodeBtnLeft, 16'h0001);
    send_event(OP_MOUSE, TypeKey, CodeBtnRight, 16'hFFFF);
    send_event(OP_MOUSE, TypeKey, CodeBtnMid, 16'h8000);
    // Button code under the wrong type, and one differing only in its high bits.
    send_event(OP_MOUSE, TypeRel, CodeBtnLeft, 16'h0000);
    send_event(OP_MOUSE, TypeKey, CodeBtnLeft | 16'h1000, 16'h0000);
    send_event(OP_MOUSE, TypeSync, CodeRelX, 16'h0100);
    send_event(OP_KBD, TypeKey, {8'h00, KeyShiftL}, 16'h0001);
    send_event(OP_KBD, TypeKey, {8'h00, KeyCtrlL}, 16'h0001);
    send_event(OP_KBD, TypeKey, {8'h00, KeyAltL}, 16'h8000);
    // Caps lock with a nonzero high byte, then a release that must not toggle.
    send_event(OP_KBD, TypeKey, {8'hFF, KeyCaps}, 16'h0001);
    send_event(OP_KBD, TypeKey, {8'h00, KeyCaps}, 16'h0000);
    send_event(OP_KBD, TypeKey, 16'h0000, 16'h0001);
    send_event(OP_KBD, TypeKey, 16'hABFF, 16'hFFFF);
    send_event(OP_KBD, TypeRel, 16'h0041, 16'h0001);
    send_event(OpUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event(OP_POLL, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Right shift release clears shift held from the left side.
    send_event(OP_KBD, TypeKey, {8'h00, KeyShiftR}, 16'h0000);
    send_event(OP_KBD, TypeKey, {8'h00, KeyCaps}, 16'h0002);
    send_event(OP_MOUSE, TypeKey, CodeBtnRight, 16'h0000);
    send_event(OP_POLL, '0, '0, '0);
    wait_idle();

    // Random phases, each at its own screen size, with idling profiles shared by pairs of phases.
    for (int p = 0; p < 6; p++) begin
      program_screen(widths[p], heights[p]);
      if (p < 2) begin
        send_idle_pct = 13;
        recv_idle_pct = 54;
      end else if (p < 4) begin
        send_idle_pct = 54;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 4) pressure_go = 1'b1;
      for (int i = 0; i < PhaseItems; i++) send_random_event();
      wait_idle();
    end

    if (tracker.mismatches == 0 && tracker.snapshots_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
